// ===== rtl/pis_pkg.sv =====
// ============================================================================
// pis_pkg: shared types and constants of the particle integration pipeline
// Transaction payloads, configuration codes, the stage payload and helpers.
// ============================================================================
`default_nettype none

package pis_pkg;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 24;
    localparam int unsigned DIV_STEPS  = 16;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_DT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KILL_ENABLE = 2'd2;

    localparam logic [15:0]        FRAME_DT_RESET = 16'd1092;
    localparam logic signed [23:0] GRAVITY_RESET  = 24'sd25600;
    localparam logic               KILL_RESET     = 1'b1;

    // Life fraction of one, Q1.16 held in 17 bits.
    localparam logic [16:0] ONE_Q16 = 17'h10000;

    typedef struct packed {
        logic [23:0]        age;
        logic [23:0]        lifetime;
        logic signed [23:0] vel_x;
        logic signed [23:0] vel_y;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] angle;
        logic signed [23:0] spin;
        logic [31:0]        start_rgba;
        logic [31:0]        end_rgba;
        logic [19:0]        start_size;
        logic [19:0]        end_size;
    } item_t;

    typedef struct packed {
        logic [23:0]        new_age;
        logic signed [23:0] new_vel_y;
        logic signed [23:0] new_pos_x;
        logic signed [23:0] new_pos_y;
        logic signed [23:0] new_angle;
        logic [31:0]        cur_rgba;
        logic [19:0]        cur_size;
        logic               alive;
    } result_t;

    typedef struct packed {
        logic [15:0]        frame_dt;
        logic signed [23:0] gravity;
        logic               kill_enable;
    } cfg_t;

    // Payload carried from the front stage through motion and the divider.
    typedef struct packed {
        logic [23:0]        nage;
        logic [23:0]        lifetime;
        logic               alive;
        logic               full;
        logic [23:0]        rem;
        logic [15:0]        quo;
        logic signed [23:0] vel_y;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] angle;
        logic signed [39:0] prod_g;
        logic signed [39:0] prod_x;
        logic signed [39:0] prod_s;
        logic [31:0]        start_rgba;
        logic [31:0]        end_rgba;
        logic [19:0]        start_size;
        logic [19:0]        end_size;
    } pipe_t;

    // Payload between the two interpolation stages.
    typedef struct packed {
        logic [23:0]        new_age;
        logic signed [23:0] new_vel_y;
        logic signed [23:0] new_pos_x;
        logic signed [23:0] new_pos_y;
        logic signed [23:0] new_angle;
        logic               alive;
        logic [31:0]        start_rgba;
        logic [19:0]        start_size;
        logic [31:0]        delta_rgba;
        logic [19:0]        delta_size;
    } lerp_t;

    // Clamp a 25-bit signed sum to the signed 24-bit range.
    function automatic logic signed [23:0] sat24(input logic signed [24:0] v);
        logic signed [23:0] r;
        if (v[24] != v[23])
        begin
            r = v[24] ? 24'sh800000 : 24'sh7FFFFF;
        end
        else
        begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pis_front.sv =====
// ============================================================================
// pis_front: first pipeline stage
// Advances the age, sets up the life-fraction division and forms the three
// frame-step products of velocity, gravity and spin.
// ============================================================================
`default_nettype none

module pis_front
    import pis_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire logic  up_valid,
    output logic       up_stall,
    input  wire item_t up_data,
    output logic       dn_valid,
    input  wire logic  dn_stall,
    output pipe_t      dn_data
);

    logic        valid_reg;
    pipe_t       data_reg;
    pipe_t       data_next;
    logic        hold;
    logic [24:0] age_sum;
    logic [23:0] nage;
    logic signed [40:0] mul_g;
    logic signed [40:0] mul_x;
    logic signed [40:0] mul_s;
    logic signed [16:0] dt_s;

    assign hold     = valid_reg & dn_stall;
    assign up_stall = hold;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_comb
    begin
        age_sum = {1'b0, up_data.age} + {9'b0, cfg.frame_dt};
        nage    = age_sum[24] ? 24'hFFFFFF : age_sum[23:0];
        dt_s    = $signed({1'b0, cfg.frame_dt});
        mul_g   = cfg.gravity * dt_s;
        mul_x   = up_data.vel_x * dt_s;
        mul_s   = up_data.spin * dt_s;

        data_next            = '0;
        data_next.nage       = nage;
        data_next.lifetime   = up_data.lifetime;
        // Reaching the lifetime caps the fraction at one; a zero lifetime lands here too.
        data_next.full       = (nage >= up_data.lifetime);
        data_next.alive      = !(cfg.kill_enable && (nage >= up_data.lifetime));
        data_next.rem        = nage;
        data_next.quo        = '0;
        data_next.vel_y      = up_data.vel_y;
        data_next.pos_x      = up_data.pos_x;
        data_next.pos_y      = up_data.pos_y;
        data_next.angle      = up_data.angle;
        data_next.prod_g     = mul_g[39:0];
        data_next.prod_x     = mul_x[39:0];
        data_next.prod_s     = mul_s[39:0];
        data_next.start_rgba = up_data.start_rgba;
        data_next.end_rgba   = up_data.end_rgba;
        data_next.start_size = up_data.start_size;
        data_next.end_size   = up_data.end_size;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!hold)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pis_motion.sv =====
// ============================================================================
// pis_motion: three motion stages
// Applies gravity, moves x and the angle, then multiplies the new vertical
// velocity by the frame step and moves y with it.
// ============================================================================
`default_nettype none

module pis_motion
    import pis_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [15:0] frame_dt,
    input  wire logic        up_valid,
    output logic             up_stall,
    input  wire pipe_t       up_data,
    output logic             dn_valid,
    input  wire logic        dn_stall,
    output pipe_t            dn_data
);

    logic  valid_a_reg, valid_b_reg, valid_c_reg;
    pipe_t data_a_reg, data_b_reg, data_c_reg;
    pipe_t data_a_next, data_b_next, data_c_next;
    logic  hold_a, hold_b, hold_c;
    logic signed [40:0] mul_y;

    assign hold_c   = valid_c_reg & dn_stall;
    assign hold_b   = valid_b_reg & hold_c;
    assign hold_a   = valid_a_reg & hold_b;
    assign up_stall = hold_a;
    assign dn_valid = valid_c_reg;
    assign dn_data  = data_c_reg;

    always_comb
    begin
        data_a_next       = up_data;
        data_a_next.vel_y = sat24($signed({up_data.vel_y[23], up_data.vel_y})
                                  + $signed({up_data.prod_g[39], up_data.prod_g[39:16]}));
        data_a_next.pos_x = sat24($signed({up_data.pos_x[23], up_data.pos_x})
                                  + $signed({up_data.prod_x[39], up_data.prod_x[39:16]}));
        // Rotation wraps, so the sum is simply kept to 24 bits.
        data_a_next.angle = up_data.angle + up_data.prod_s[39:16];
    end

    always_comb
    begin
        mul_y              = data_a_reg.vel_y * $signed({1'b0, frame_dt});
        data_b_next        = data_a_reg;
        data_b_next.prod_g = mul_y[39:0];
    end

    always_comb
    begin
        data_c_next       = data_b_reg;
        data_c_next.pos_y = sat24($signed({data_b_reg.pos_y[23], data_b_reg.pos_y})
                                  + $signed({data_b_reg.prod_g[39],
                                             data_b_reg.prod_g[39:16]}));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
        end
        else
        begin
            if (!hold_a)
            begin
                valid_a_reg <= up_valid;
            end
            if (!hold_b)
            begin
                valid_b_reg <= valid_a_reg;
            end
            if (!hold_c)
            begin
                valid_c_reg <= valid_b_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold_a)
        begin
            data_a_reg <= data_a_next;
        end
        if (!hold_b)
        begin
            data_b_reg <= data_b_next;
        end
        if (!hold_c)
        begin
            data_c_reg <= data_c_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pis_div_stage.sv =====
// ============================================================================
// pis_div_stage: one restoring division step
// Produces one quotient bit of age times 2^16 over lifetime per stage.
// ============================================================================
`default_nettype none

module pis_div_stage
    import pis_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  up_valid,
    output logic       up_stall,
    input  wire pipe_t up_data,
    output logic       dn_valid,
    input  wire logic  dn_stall,
    output pipe_t      dn_data
);

    logic        valid_reg;
    pipe_t       data_reg;
    pipe_t       data_next;
    logic        hold;
    logic [24:0] twice;
    logic [24:0] diff;
    logic        fits;

    assign hold     = valid_reg & dn_stall;
    assign up_stall = hold;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_comb
    begin
        twice = {up_data.rem, 1'b0};
        diff  = twice - {1'b0, up_data.lifetime};
        fits  = (twice >= {1'b0, up_data.lifetime});

        // The remainder stays below the lifetime whenever the quotient is used.
        data_next     = up_data;
        data_next.rem = fits ? diff[23:0] : twice[23:0];
        data_next.quo = {up_data.quo[14:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!hold)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pis_lerp.sv =====
// ============================================================================
// pis_lerp: colour and size interpolation, two stages
// Multiplies each end-minus-start difference by the life fraction, then adds
// the floored step to the start value into the result register.
// ============================================================================
`default_nettype none

module pis_lerp
    import pis_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  up_valid,
    output logic       up_stall,
    input  wire pipe_t up_data,
    output logic       dn_valid,
    input  wire logic  dn_stall,
    output result_t    dn_data
);

    logic    valid_a_reg, valid_b_reg;
    lerp_t   data_a_reg;
    lerp_t   data_a_next;
    result_t data_b_reg;
    result_t data_b_next;
    logic    hold_a, hold_b;

    logic [16:0]        frac;
    logic signed [8:0]  ch_diff;
    logic signed [25:0] ch_prod;
    logic signed [20:0] sz_diff;
    logic signed [37:0] sz_prod;

    assign hold_b   = valid_b_reg & dn_stall;
    assign hold_a   = valid_a_reg & hold_b;
    assign up_stall = hold_a;
    assign dn_valid = valid_b_reg;
    assign dn_data  = data_b_reg;

    always_comb
    begin
        frac = up_data.full ? ONE_Q16 : {1'b0, up_data.quo};

        data_a_next            = '0;
        data_a_next.new_age    = up_data.nage;
        data_a_next.new_vel_y  = up_data.vel_y;
        data_a_next.new_pos_x  = up_data.pos_x;
        data_a_next.new_pos_y  = up_data.pos_y;
        data_a_next.new_angle  = up_data.angle;
        data_a_next.alive      = up_data.alive;
        data_a_next.start_rgba = up_data.start_rgba;
        data_a_next.start_size = up_data.start_size;

        ch_diff = '0;
        ch_prod = '0;
        for (int i = 0; i < 4; i++)
        begin
            ch_diff = $signed({1'b0, up_data.end_rgba[8*i +: 8]})
                      - $signed({1'b0, up_data.start_rgba[8*i +: 8]});
            ch_prod = 26'(ch_diff * $signed({1'b0, frac}));
            // Only the low bits of the floored step matter: the sum stays in range.
            data_a_next.delta_rgba[8*i +: 8] = ch_prod[23:16];
        end

        sz_diff = $signed({1'b0, up_data.end_size}) - $signed({1'b0, up_data.start_size});
        sz_prod = 38'(sz_diff * $signed({1'b0, frac}));
        data_a_next.delta_size = sz_prod[35:16];
    end

    always_comb
    begin
        data_b_next           = '0;
        data_b_next.new_age   = data_a_reg.new_age;
        data_b_next.new_vel_y = data_a_reg.new_vel_y;
        data_b_next.new_pos_x = data_a_reg.new_pos_x;
        data_b_next.new_pos_y = data_a_reg.new_pos_y;
        data_b_next.new_angle = data_a_reg.new_angle;
        data_b_next.alive     = data_a_reg.alive;
        for (int i = 0; i < 4; i++)
        begin
            data_b_next.cur_rgba[8*i +: 8] = data_a_reg.start_rgba[8*i +: 8]
                                             + data_a_reg.delta_rgba[8*i +: 8];
        end
        data_b_next.cur_size = data_a_reg.start_size + data_a_reg.delta_size;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else
        begin
            if (!hold_a)
            begin
                valid_a_reg <= up_valid;
            end
            if (!hold_b)
            begin
                valid_b_reg <= valid_a_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold_a)
        begin
            data_a_reg <= data_a_next;
        end
        if (!hold_b)
        begin
            data_b_reg <= data_b_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/particle_integrate_step.sv =====
// ============================================================================
// particle_integrate_step: one-frame update of a particle record
// Semi-implicit Euler motion, life fraction, colour and size interpolation.
// ============================================================================
// Usage. A particle record arrives as a transaction on the item channel
// (item_valid, item_stall, item) and the advanced record leaves as a
// transaction on the result channel (result_valid, result_stall, result).
// A transaction completes at a clock edge where valid is high and stall low.
// Frame step, gravity and the kill switch are written through cfg_we,
// cfg_index and cfg_wdata, one register per cycle, while no record is in flight.
// The pipe has one front stage, three motion stages, sixteen
// division stages (one quotient bit of the life fraction each) and two
// interpolation stages. The divider chain sets the depth; unless stalled,
// one record may enter on every cycle, so throughput is one record per cycle.
// Reset clears every stage's valid bit and loads the register defaults.
// When the receiver stalls, each full stage holds its contents; empty stages
// ahead of it keep filling, so item_stall rises only once the pipe is full,
// and nothing is dropped or repeated.
// ============================================================================
`default_nettype none

module particle_integrate_step
    import pis_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  item_valid,
    output logic                       item_stall,
    input  wire item_t                 item,
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output result_t                    result
);

    // Config registers: user changes them only between bursts of records; not enforced.
    logic [15:0]        frame_dt_reg;
    logic signed [23:0] gravity_reg;
    logic               kill_enable_reg;
    cfg_t               cfg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_dt_reg    <= FRAME_DT_RESET;
            gravity_reg     <= GRAVITY_RESET;
            kill_enable_reg <= KILL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_DT:    frame_dt_reg    <= cfg_wdata[15:0];
                REG_GRAVITY:     gravity_reg     <= cfg_wdata;
                REG_KILL_ENABLE: kill_enable_reg <= cfg_wdata[0];
                default:         ; // Writes past the last register are dropped.
            endcase
        end
    end

    assign cfg.frame_dt    = frame_dt_reg;
    assign cfg.gravity     = gravity_reg;
    assign cfg.kill_enable = kill_enable_reg;

    // Front stage: new age, division set-up and the frame-step products.
    logic  front_valid;
    logic  front_stall;
    pipe_t front_data;

    pis_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .up_valid (item_valid),
        .up_stall (item_stall),
        .up_data  (item),
        .dn_valid (front_valid),
        .dn_stall (front_stall),
        .dn_data  (front_data)
    );

    // Motion stages. Their outputs ride along while the divider works.
    logic div_valid [DIV_STEPS+1];
    logic div_stall [DIV_STEPS+1];
    pipe_t div_data [DIV_STEPS+1];

    pis_motion u_motion (
        .clk      (clk),
        .rst_n    (rst_n),
        .frame_dt (frame_dt_reg),
        .up_valid (front_valid),
        .up_stall (front_stall),
        .up_data  (front_data),
        .dn_valid (div_valid[0]),
        .dn_stall (div_stall[0]),
        .dn_data  (div_data[0])
    );

    // Life fraction: one restoring step per stage, most significant bit first.
    for (genvar g = 0; g < DIV_STEPS; g++)
    begin : g_div
        pis_div_stage u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (div_valid[g]),
            .up_stall (div_stall[g]),
            .up_data  (div_data[g]),
            .dn_valid (div_valid[g+1]),
            .dn_stall (div_stall[g+1]),
            .dn_data  (div_data[g+1])
        );
    end

    // Interpolation; its second stage is the result register.
    pis_lerp u_lerp (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (div_valid[DIV_STEPS]),
        .up_stall (div_stall[DIV_STEPS]),
        .up_data  (div_data[DIV_STEPS]),
        .dn_valid (result_valid),
        .dn_stall (result_stall),
        .dn_data  (result)
    );

endmodule

`default_nettype wire
